[rtl/tgs_pkg.sv]
package tgs_pkg;

    localparam int DIM_BITS       = 14;
    localparam int CNT_BITS       = 6;
    localparam int MAX_TILE_LIMIT = 63;
    localparam int DIST_BITS      = DIM_BITS + CNT_BITS;
    localparam int PROD_BITS      = DIST_BITS + CNT_BITS;
    localparam int STEP_BITS      = $clog2(DIM_BITS);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = CNT_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_TILES = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_TILES = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THUMB_EN  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_DIVW_GO,
        ST_DIVW_WAIT,
        ST_DIVH_GO,
        ST_DIVH_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                start;
        logic [DIM_BITS-1:0] dividend;
        logic [CNT_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIM_BITS-1:0] quo;
        logic [CNT_BITS-1:0] rem;
    } t_div_rsp;

endpackage

[rtl/tgs_img_if.sv]
interface tgs_img_if;
    import tgs_pkg::*;

    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] image_width;
    logic [DIM_BITS-1:0] image_height;

    modport source (output valid, output image_width, output image_height, input ready);
    modport sink   (input valid, input image_width, input image_height, output ready);
endinterface

[rtl/tgs_rect_if.sv]
interface tgs_rect_if;
    import tgs_pkg::*;

    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] rect_x;
    logic [DIM_BITS-1:0] rect_y;
    logic [DIM_BITS-1:0] rect_width;
    logic [DIM_BITS-1:0] rect_height;
    logic [CNT_BITS-1:0] grid_columns;
    logic [CNT_BITS-1:0] grid_rows;
    logic                is_thumbnail;
    logic                last;

    modport source (
        output valid, output rect_x, output rect_y, output rect_width, output rect_height,
        output grid_columns, output grid_rows, output is_thumbnail, output last,
        input ready
    );
    modport sink (
        input valid, input rect_x, input rect_y, input rect_width, input rect_height,
        input grid_columns, input grid_rows, input is_thumbnail, input last,
        output ready
    );
endinterface

[rtl/tgs_div.sv]
module tgs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tgs_pkg::t_div_req i_req,
    output tgs_pkg::t_div_rsp o_rsp
);
    import tgs_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_cnt;
    logic [DIM_BITS-1:0]  r_quo;
    logic [CNT_BITS-1:0]  r_rem;
    logic [CNT_BITS-1:0]  r_div;

    logic [CNT_BITS:0]    w_trial;
    logic                 w_ge;
    logic [CNT_BITS:0]    w_diff;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_quo[DIM_BITS-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_BITS'(DIM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIM_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_BITS-1:0] : w_trial[CNT_BITS-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

[rtl/tile_grid_select_and_emit_core.sv]
// Takes one image size, picks the tile grid (cols x rows, tile count within
// min_tiles..max_tiles) whose cols/rows is closest to width/height, and sends
// the tile rectangles in raster order, then a whole-image thumbnail when that
// is enabled and the grid has several tiles. One image is handled at a time:
// the grid search checks one candidate grid per cycle (rows of candidates are
// cut short once the tile count passes max_tiles), then a drain state empties
// the compare stage, then a bit-serial divider works out the tile width and
// then the tile height, then one rectangle leaves per cycle while the sink
// takes them. The input is ready again once the last rectangle sits in the
// output register.
module tile_grid_select_and_emit_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tgs_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [tgs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    tgs_img_if.sink                            i_img,
    tgs_rect_if.source                         o_rect
);
    import tgs_pkg::*;

    // configuration
    logic [CNT_BITS-1:0] r_min_tiles;
    logic [CNT_BITS-1:0] r_max_tiles;
    logic                r_thumb_en;

    t_state r_state;
    t_state n_state;

    // image
    logic [DIM_BITS-1:0] r_w;
    logic [DIM_BITS-1:0] r_h;

    // candidate sequencer
    logic [CNT_BITS-1:0] r_n, r_i, r_j;
    logic                r_first;
    logic [CNT_BITS-1:0] n_n, n_i, n_j;
    logic                n_first;
    logic                w_search_end;

    // compare pipeline
    logic                 r_a_valid;
    logic [CNT_BITS-1:0]  r_a_i, r_a_j, r_a_t;
    logic [DIST_BITS-1:0] r_a_wj, r_a_ih;

    // best grid
    logic                 r_found;
    logic [CNT_BITS-1:0]  r_best_i, r_best_j, r_best_t;
    logic [DIST_BITS-1:0] r_best_d;

    // emission
    logic [DIM_BITS-1:0] r_wq, r_hq;
    logic [CNT_BITS-1:0] r_wr, r_hr;
    logic [CNT_BITS-1:0] r_col, r_row;
    logic [DIM_BITS-1:0] r_xq, r_yq;
    logic [CNT_BITS-1:0] r_xr, r_yr;
    logic                r_in_thumb;

    // output register
    logic                r_out_valid;
    logic [DIM_BITS-1:0] r_o_x, r_o_y, r_o_w, r_o_h;
    logic [CNT_BITS-1:0] r_o_cols, r_o_rows;
    logic                r_o_thumb, r_o_last;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic                   w_accept;
    logic                   w_in_ready;
    logic [CNT_BITS-1:0]    w_hi;
    logic [CNT_BITS-1:0]    w_n0;
    logic [DIM_BITS-1:0]    w_in_w, w_in_h;
    logic [2*CNT_BITS-1:0]  w_t;
    logic                   w_over;
    logic                   w_cand;
    logic [DIST_BITS-1:0]   w_wj, w_ih, w_d;
    logic [PROD_BITS-1:0]   w_lhs, w_rhs;
    logic                   w_better;
    logic                   w_thumb;
    logic                   w_last_col, w_last_row, w_tile_last, w_final;
    logic                   w_load;
    logic [CNT_BITS:0]      w_xsum, w_ysum;
    logic                   w_xwrap, w_ywrap;
    logic [DIM_BITS-1:0]    w_tw, w_th;

    tgs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_accept = i_img.valid && w_in_ready;
    assign w_hi     = (r_max_tiles > CNT_BITS'(MAX_TILE_LIMIT)) ?
                      CNT_BITS'(MAX_TILE_LIMIT) : r_max_tiles;
    assign w_n0     = (r_min_tiles == '0) ? CNT_BITS'(1) : r_min_tiles;
    assign w_in_w   = (i_img.image_width == '0) ? DIM_BITS'(1) : i_img.image_width;
    assign w_in_h   = (i_img.image_height == '0) ? DIM_BITS'(1) : i_img.image_height;

    // candidate check
    assign w_t    = r_i * r_j;
    assign w_over = w_t > {{CNT_BITS{1'b0}}, w_hi};
    assign w_cand = (r_state == ST_SEARCH) && !w_over &&
                    (w_t >= {{CNT_BITS{1'b0}}, r_min_tiles});
    assign w_wj   = r_w * r_j;
    assign w_ih   = r_h * r_i;

    // Visit each grid once, in the order of its first appearance: the full
    // square for the first tile count, then for each larger count n only the
    // new column j = n and row i = n. Tile count grows along i and j, so
    // drop the rest of a line once it passes the maximum.
    always_comb begin
        n_n          = r_n;
        n_i          = r_i;
        n_j          = r_j;
        n_first      = r_first;
        w_search_end = 1'b0;
        if (r_i == r_n) begin
            if (w_over || r_j == r_n) begin
                if (r_n == w_hi) begin
                    w_search_end = 1'b1;
                end else begin
                    n_n     = r_n + 1'b1;
                    n_i     = CNT_BITS'(1);
                    n_j     = r_n + 1'b1;
                    n_first = 1'b0;
                end
            end else begin
                n_j = r_j + 1'b1;
            end
        end else if (r_first) begin
            if (w_over || r_j == r_n) begin
                n_i = r_i + 1'b1;
                n_j = CNT_BITS'(1);
            end else begin
                n_j = r_j + 1'b1;
            end
        end else begin
            if (w_over || (r_i + 1'b1) == r_n) begin
                n_i = r_n;
                n_j = CNT_BITS'(1);
            end else begin
                n_i = r_i + 1'b1;
            end
        end
    end

    // exact distance compare: |W*j - i*H| / (H*j), H cancels
    assign w_d      = (r_a_wj >= r_a_ih) ? (r_a_wj - r_a_ih) : (r_a_ih - r_a_wj);
    assign w_lhs    = w_d * r_best_j;
    assign w_rhs    = r_best_d * r_a_j;
    assign w_better = !r_found || (w_lhs < w_rhs) ||
                      ((w_lhs == w_rhs) && (r_a_t > r_best_t));

    // emission
    assign w_thumb     = r_thumb_en && (r_best_t != CNT_BITS'(1));
    assign w_last_col  = r_col == (r_best_i - 1'b1);
    assign w_last_row  = r_row == (r_best_j - 1'b1);
    assign w_tile_last = w_last_col && w_last_row;
    assign w_final     = r_in_thumb || (w_tile_last && !w_thumb);
    assign w_xsum      = {1'b0, r_xr} + {1'b0, r_wr};
    assign w_ysum      = {1'b0, r_yr} + {1'b0, r_hr};
    assign w_xwrap     = w_xsum >= {1'b0, r_best_i};
    assign w_ywrap     = w_ysum >= {1'b0, r_best_j};
    assign w_tw        = (r_wq == '0) ? DIM_BITS'(1) : r_wq;
    assign w_th        = (r_hq == '0) ? DIM_BITS'(1) : r_hq;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_n0 <= w_hi) ? ST_SEARCH : ST_DRAIN;
                end
            end
            ST_SEARCH: begin
                if (w_search_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:     n_state = ST_DIVW_GO;
            ST_DIVW_GO:   n_state = ST_DIVW_WAIT;
            ST_DIVW_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = ST_DIVH_GO;
                end
            end
            ST_DIVH_GO:   n_state = ST_DIVH_WAIT;
            ST_DIVH_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_load && w_final) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready         = 1'b0;
        w_load             = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_w;
        w_div_req.divisor  = r_best_i;
        case (r_state)
            ST_IDLE:    w_in_ready = 1'b1;
            ST_DIVW_GO: w_div_req.start = 1'b1;
            ST_DIVH_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = r_h;
                w_div_req.divisor  = r_best_j;
            end
            ST_EMIT:    w_load = !r_out_valid || o_rect.ready;
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_min_tiles <= CNT_BITS'(1);
            r_max_tiles <= CNT_BITS'(12);
            r_thumb_en  <= 1'b1;
            r_a_valid   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_thumb  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_a_valid <= w_cand;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_TILES: r_min_tiles <= i_cfg_data;
                    CFG_MAX_TILES: r_max_tiles <= i_cfg_data;
                    CFG_THUMB_EN:  r_thumb_en  <= i_cfg_data[0];
                    default:       r_thumb_en  <= r_thumb_en;
                endcase
            end
            if (w_accept) begin
                r_found    <= 1'b0;
                r_in_thumb <= 1'b0;
            end else if (r_a_valid && w_better) begin
                r_found <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (!r_in_thumb && w_tile_last && w_thumb) begin
                    r_in_thumb <= 1'b1;
                end
            end else if (o_rect.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_w      <= w_in_w;
            r_h      <= w_in_h;
            r_n      <= w_n0;
            r_i      <= CNT_BITS'(1);
            r_j      <= CNT_BITS'(1);
            r_first  <= 1'b1;
            r_best_i <= CNT_BITS'(1);
            r_best_j <= CNT_BITS'(1);
            r_best_t <= CNT_BITS'(1);
            r_best_d <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_xq     <= '0;
            r_xr     <= '0;
            r_yq     <= '0;
            r_yr     <= '0;
        end else begin
            if (r_state == ST_SEARCH) begin
                r_n     <= n_n;
                r_i     <= n_i;
                r_j     <= n_j;
                r_first <= n_first;
            end
            if (r_a_valid && w_better) begin
                r_best_i <= r_a_i;
                r_best_j <= r_a_j;
                r_best_t <= r_a_t;
                r_best_d <= w_d;
            end
            if (w_load && !r_in_thumb) begin
                if (w_last_col) begin
                    r_col <= '0;
                    r_xq  <= '0;
                    r_xr  <= '0;
                    if (!w_last_row) begin
                        r_row <= r_row + 1'b1;
                        r_yq  <= r_yq + r_hq + DIM_BITS'(w_ywrap);
                        r_yr  <= w_ywrap ? CNT_BITS'(w_ysum - {1'b0, r_best_j})
                                         : w_ysum[CNT_BITS-1:0];
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                    r_xq  <= r_xq + r_wq + DIM_BITS'(w_xwrap);
                    r_xr  <= w_xwrap ? CNT_BITS'(w_xsum - {1'b0, r_best_i})
                                     : w_xsum[CNT_BITS-1:0];
                end
            end
        end
        r_a_i  <= r_i;
        r_a_j  <= r_j;
        r_a_t  <= w_t[CNT_BITS-1:0];
        r_a_wj <= w_wj;
        r_a_ih <= w_ih;
        if (r_state == ST_DIVW_WAIT && w_div_rsp.done) begin
            r_wq <= w_div_rsp.quo;
            r_wr <= w_div_rsp.rem;
        end
        if (r_state == ST_DIVH_WAIT && w_div_rsp.done) begin
            r_hq <= w_div_rsp.quo;
            r_hr <= w_div_rsp.rem;
        end
        if (w_load) begin
            r_o_cols <= r_best_i;
            r_o_rows <= r_best_j;
            if (r_in_thumb) begin
                r_o_x     <= '0;
                r_o_y     <= '0;
                r_o_w     <= r_w;
                r_o_h     <= r_h;
                r_o_thumb <= 1'b1;
                r_o_last  <= 1'b1;
            end else begin
                r_o_x     <= r_xq;
                r_o_y     <= r_yq;
                r_o_w     <= w_tw;
                r_o_h     <= w_th;
                r_o_thumb <= 1'b0;
                r_o_last  <= w_tile_last && !w_thumb;
            end
        end
    end

    assign i_img.ready         = w_in_ready;
    assign o_rect.valid        = r_out_valid;
    assign o_rect.rect_x       = r_o_x;
    assign o_rect.rect_y       = r_o_y;
    assign o_rect.rect_width   = r_o_w;
    assign o_rect.rect_height  = r_o_h;
    assign o_rect.grid_columns = r_o_cols;
    assign o_rect.grid_rows    = r_o_rows;
    assign o_rect.is_thumbnail = r_o_thumb;
    assign o_rect.last         = r_o_last;

    a_accept_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SEARCH) || (r_state == ST_DRAIN))
        else $error("image transfer did not start the grid search");

    a_compare_only_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_state == ST_SEARCH) || (r_state == ST_DRAIN))
        else $error("candidate compare active outside the search");

    a_tile_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) && !r_in_thumb |-> (r_col < r_best_i) && (r_row < r_best_j))
        else $error("tile position outside the chosen grid");

endmodule

[verif/tb_tile_grid_select_and_emit_core.sv]
`timescale 1ns / 1ps
module tb_tile_grid_select_and_emit_core;
    import tgs_pkg::*;

    localparam int WATCHDOG_LIMIT  = 100000;
    localparam int END_WAIT        = 300;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int FIXED_PHASES    = 9;
    localparam int NUM_PHASES      = 12;
    localparam int NUM_DIRECTED    = 12;
    localparam int NUM_NARROW      = 4;

    typedef struct packed {
        logic [DIM_BITS-1:0] x;
        logic [DIM_BITS-1:0] y;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
        logic [CNT_BITS-1:0] cols;
        logic [CNT_BITS-1:0] rows;
        logic                thumb;
        logic                last;
    } t_rect;

    class t_rect_scoreboard;
        logic [CNT_BITS-1:0] min_tiles;
        logic [CNT_BITS-1:0] max_tiles;
        logic                thumb_en;
        t_rect               expected_rects[$];
        int                  errors;

        function new();
            min_tiles = CNT_BITS'(1);
            max_tiles = CNT_BITS'(12);
            thumb_en  = 1'b1;
            errors    = 0;
        endfunction

        function void set_config(logic [CNT_BITS-1:0] lo, logic [CNT_BITS-1:0] hi, logic th);
            min_tiles = lo;
            max_tiles = hi;
            thumb_en  = th;
        endfunction

        function int pending();
            return expected_rects.size();
        endfunction

        function void queue_rect(t_rect r);
            expected_rects = {expected_rects, r};
        endfunction

        // Pick the grid by exact rational distance, then lay out the tiles.
        function void note_image(logic [DIM_BITS-1:0] w_in, logic [DIM_BITS-1:0] h_in);
            bit [DIM_BITS-1:0]  w, h, tw, th;
            bit [DIST_BITS-1:0] d, best_d, wj, ih;
            bit [PROD_BITS-1:0] lhs, rhs;
            int                 lo, hi, n, i, j, t, bi, bj, k, blocks;
            bit                 found, with_thumb;
            t_rect              r;
            w = (w_in == '0) ? DIM_BITS'(1) : w_in;
            h = (h_in == '0) ? DIM_BITS'(1) : h_in;
            lo = int'(min_tiles);
            hi = int'(max_tiles);
            if (hi > MAX_TILE_LIMIT) hi = MAX_TILE_LIMIT;
            bi = 1;
            bj = 1;
            best_d = '0;
            found = 1'b0;
            for (n = lo; n <= hi; n++) begin
                for (i = 1; i <= n; i++) begin
                    for (j = 1; j <= n; j++) begin
                        t = i * j;
                        if (t > hi) break;
                        if (t < lo) continue;
                        wj = DIST_BITS'(w * j);
                        ih = DIST_BITS'(i * h);
                        d = (wj >= ih) ? wj - ih : ih - wj;
                        lhs = PROD_BITS'(d * bj);
                        rhs = PROD_BITS'(best_d * j);
                        if (!found || lhs < rhs) begin
                            found = 1'b1;
                            bi = i;
                            bj = j;
                            best_d = d;
                        end else if (lhs == rhs && t > bi * bj) begin
                            bi = i;
                            bj = j;
                            best_d = d;
                        end
                    end
                end
            end
            blocks = bi * bj;
            with_thumb = thumb_en && (blocks != 1);
            tw = DIM_BITS'(w / bi);
            th = DIM_BITS'(h / bj);
            if (tw == '0) tw = DIM_BITS'(1);
            if (th == '0) th = DIM_BITS'(1);
            for (k = 0; k < blocks; k++) begin
                r.x     = DIM_BITS'(((k % bi) * w) / bi);
                r.y     = DIM_BITS'(((k / bi) * h) / bj);
                r.w     = tw;
                r.h     = th;
                r.cols  = CNT_BITS'(bi);
                r.rows  = CNT_BITS'(bj);
                r.thumb = 1'b0;
                r.last  = !with_thumb && (k + 1 == blocks);
                queue_rect(r);
            end
            if (with_thumb) begin
                r.x     = '0;
                r.y     = '0;
                r.w     = w;
                r.h     = h;
                r.cols  = CNT_BITS'(bi);
                r.rows  = CNT_BITS'(bj);
                r.thumb = 1'b1;
                r.last  = 1'b1;
                queue_rect(r);
            end
        endfunction

        function void check_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_rect(t_rect act);
            t_rect exp_r;
            if (expected_rects.size() == 0) begin
                errors++;
                $display("%0t: unexpected rect: expected none, got x=%0d y=%0d w=%0d h=%0d",
                         $time, act.x, act.y, act.w, act.h);
                return;
            end
            exp_r = expected_rects.pop_front();
            check_field("rect_x", 32'(exp_r.x), 32'(act.x));
            check_field("rect_y", 32'(exp_r.y), 32'(act.y));
            check_field("rect_width", 32'(exp_r.w), 32'(act.w));
            check_field("rect_height", 32'(exp_r.h), 32'(act.h));
            check_field("grid_columns", 32'(exp_r.cols), 32'(act.cols));
            check_field("grid_rows", 32'(exp_r.rows), 32'(act.rows));
            check_field("is_thumbnail", 32'(exp_r.thumb), 32'(act.thumb));
            check_field("last", 32'(exp_r.last), 32'(act.last));
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     no_gaps;
    int                       quiet_cycles = 0;
    t_rect_scoreboard         sb;

    int unsigned directed_w [NUM_DIRECTED] = '{1, 16383, 16383, 1, 0, 0, 16383, 10922, 5461,
                                               1920, 448, 3};
    int unsigned directed_h [NUM_DIRECTED] = '{1, 16383, 1, 16383, 0, 16383, 0, 5461, 10922,
                                               1080, 448, 7};
    int unsigned narrow_w [NUM_NARROW] = '{3, 10, 1, 16383};
    int unsigned narrow_h [NUM_NARROW] = '{3, 1, 10, 1};

    int unsigned phase_min   [FIXED_PHASES] = '{1, 63, 0, 1, 12, 0, 2, 4, 1};
    int unsigned phase_max   [FIXED_PHASES] = '{12, 63, 63, 1, 6, 0, 8, 24, 63};
    int unsigned phase_thumb [FIXED_PHASES] = '{1, 0, 1, 1, 1, 0, 0, 1, 1};

    tgs_img_if  img ();
    tgs_rect_if rect ();

    tile_grid_select_and_emit_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_img      (img),
        .o_rect     (rect)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : rect_sink
        t_rect got;
        if (i_rst_n && rect.valid && rect.ready) begin
            got = '{rect.rect_x, rect.rect_y, rect.rect_width, rect.rect_height,
                    rect.grid_columns, rect.grid_rows, rect.is_thumbnail, rect.last};
            sb.check_rect(got);
        end
        rect.ready <= no_gaps || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge i_clk) begin
        if ((img.valid && img.ready) || (rect.valid && rect.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_image(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 40);
        if (gap > 0) begin
            img.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        img.valid        <= 1'b1;
        img.image_width  <= w;
        img.image_height <= h;
        do @(posedge i_clk); while (!img.ready);
        sb.note_image(w, h);
    endtask

    // Hold the sender until every expected rect has come out.
    task automatic hold_until_drained();
        img.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_config(input int unsigned lo, input int unsigned hi,
                                input int unsigned th);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MIN_TILES;
        cfg_data <= CFG_DATA_BITS'(lo);
        @(posedge i_clk);
        cfg_idx  <= CFG_MAX_TILES;
        cfg_data <= CFG_DATA_BITS'(hi);
        @(posedge i_clk);
        cfg_idx  <= CFG_THUMB_EN;
        cfg_data <= CFG_DATA_BITS'(th);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_config(CNT_BITS'(lo), CNT_BITS'(hi), th[0]);
    endtask

    function automatic logic [DIM_BITS-1:0] pick_extreme();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return DIM_BITS'(1);
            default: return '1;
        endcase
    endfunction

    task automatic random_image(output logic [DIM_BITS-1:0] w, output logic [DIM_BITS-1:0] h);
        int kind, a, b, k;
        logic [DIM_BITS-1:0] tmp;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            w = DIM_BITS'($urandom_range(0, 16383));
            h = DIM_BITS'($urandom_range(0, 16383));
        end else if (kind <= 5) begin
            w = DIM_BITS'($urandom_range(1, 64));
            h = DIM_BITS'($urandom_range(1, 64));
        end else if (kind <= 7) begin
            // exact small ratios, where distance ties are common
            a = $urandom_range(1, 8);
            b = $urandom_range(1, 8);
            k = $urandom_range(1, 16383 / ((a > b) ? a : b));
            w = DIM_BITS'(a * k);
            h = DIM_BITS'(b * k);
        end else if (kind == 8) begin
            w = pick_extreme();
            h = pick_extreme();
        end else begin
            w = DIM_BITS'($urandom_range(8000, 16383));
            h = DIM_BITS'($urandom_range(1, 40));
            if ($urandom_range(0, 1)) begin
                tmp = w;
                w = h;
                h = tmp;
            end
        end
    endtask

    initial begin
        int                  p, k;
        int unsigned         lo, hi, th;
        logic [DIM_BITS-1:0] w, h;
        sb = new();
        no_gaps           <= 1'b0;
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_MIN_TILES;
        cfg_data          <= '0;
        img.valid         <= 1'b0;
        img.image_width   <= '0;
        img.image_height  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < NUM_DIRECTED; k++) begin
            send_image(DIM_BITS'(directed_w[k]), DIM_BITS'(directed_h[k]));
        end
        hold_until_drained();
        write_config(1, 63, 1);
        for (k = 0; k < NUM_NARROW; k++) begin
            send_image(DIM_BITS'(narrow_w[k]), DIM_BITS'(narrow_h[k]));
        end
        hold_until_drained();

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p < FIXED_PHASES) begin
                lo = phase_min[p];
                hi = phase_max[p];
                th = phase_thumb[p];
            end else begin
                lo = $urandom_range(0, 20);
                hi = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(lo, 63);
                th = $urandom_range(0, 1);
            end
            write_config(lo, hi, th);
            no_gaps <= (p == 3);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p == 5 && k == ITEMS_PER_PHASE / 2) hold_until_drained();
                random_image(w, h);
                send_image(w, h);
            end
            hold_until_drained();
        end

        repeat (END_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
